FILE: rtl/mlv_pkg.sv
`timescale 1ns / 1ps

package mlv_pkg;

    // table size and register map
    localparam int TABLE_POINTS_DEF = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_POINT0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POINT1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POINT2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POINT3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAXD   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MULT   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 3'd7;

    localparam logic [31:0] POINT_RESET [4] = '{32'd60211, 32'd3986227,
                                                32'd26261504, 32'd65577574};
    localparam logic [2:0]  COUNT_RESET = 3'd4;
    localparam logic [15:0] MULT_RESET  = 16'd4096;

    // result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_AMP  = 2'd1;
    localparam logic [1:0] ST_DIST = 2'd2;

    // shared multiplier and divider sizes
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;
    localparam int DIV_W  = 50;
    localparam int DIV_CNT_W = 6;
    localparam int SQ_STEPS = 24;

    localparam logic signed [MUL_W-1:0] KM_PER_DEG_Q16 = 33'sd7287271;
    localparam logic signed [MUL_W-1:0] LOG10_2_Q32    = 33'sd1292913986;

    localparam logic signed [PROD_W-1:0] MAG_MAX = 66'sd524287;
    localparam logic signed [PROD_W-1:0] MAG_MIN = -66'sd524288;

    typedef enum logic [3:0] {
        S_IDLE,
        S_KM,
        S_KM_W,
        S_SEG,
        S_INTERP,
        S_INTERP_W,
        S_DIV,
        S_NORM,
        S_SQ,
        S_SQ_W,
        S_LOG,
        S_LOG_W,
        S_CORR,
        S_CORR_W,
        S_FIN
    } state_t;

    // round to nearest by 2^28, ties away from zero
    function automatic logic signed [PROD_W-1:0] round_q28(
        input logic signed [PROD_W-1:0] v
    );
        logic [PROD_W-1:0] m;
        m = v[PROD_W-1] ? -v : v;
        m = (m + (66'd1 << 27)) >> 28;
        return v[PROD_W-1] ? -$signed(m) : $signed(m);
    endfunction

endpackage

FILE: rtl/mlv_in_if.sv
`timescale 1ns / 1ps

interface mlv_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] amplitude_q16;
    logic [23:0] distance_deg_q16;

    modport source (output valid, output amplitude_q16, output distance_deg_q16,
                    input ready);
    modport sink (input valid, input amplitude_q16, input distance_deg_q16,
                  output ready);
endinterface

FILE: rtl/mlv_out_if.sv
`timescale 1ns / 1ps

interface mlv_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic signed [19:0] magnitude_q12;

    modport source (output valid, output status, output magnitude_q12, input ready);
    modport sink (input valid, input status, input magnitude_q12, output ready);
endinterface

FILE: rtl/mlv_cfg_if.sv
`timescale 1ns / 1ps

interface mlv_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/mlv_mul.sv
`timescale 1ns / 1ps

module mlv_mul
    import mlv_pkg::*;
(
    input  logic                     clk,
    input  logic signed [MUL_W-1:0]  a,
    input  logic signed [MUL_W-1:0]  b,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;

    // one registered signed product per cycle
    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(a) * PROD_W'(b);
    end

    assign prod = prod_reg;

endmodule

FILE: rtl/mlv_div.sv
`timescale 1ns / 1ps

module mlv_div
    import mlv_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [15:0]      divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    logic [DIV_W-1:0]     dvd_reg, dvd_next;
    logic [15:0]          rem_reg, rem_next;
    logic [15:0]          dsr_reg;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    logic [16:0]          trial;
    logic                 qbit;

    // one quotient bit per cycle, restoring
    assign trial = {rem_reg, dvd_reg[DIV_W-1]};
    assign qbit  = (trial >= {1'b0, dsr_reg});

    always_comb
    begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (cnt_reg != '0)
        begin
            dvd_next = {dvd_reg[DIV_W-2:0], qbit};
            rem_next = qbit ? 16'(trial - {1'b0, dsr_reg}) : trial[15:0];
            cnt_next = cnt_reg - 1'b1;
            done_next = (cnt_reg == DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= DIV_CNT_W'(DIV_W);
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

FILE: rtl/local_magnitude_mlv.sv
`timescale 1ns / 1ps

// channel   dir  payload                             handshake
// sample    in   amplitude_q16, distance_deg_q16     valid/ready
// result    out  status, magnitude_q12               valid/ready
// cfg       in   index, data                         valid/ready (ready always high)
//
// One word at a time; sample.ready is high only while the sequencer is idle.
// Zero amplitude goes straight to the end state; distance rejects end after the
// range check or the segment scan. The full path waits on the divider, then
// normalizes the amplitude by one-bit shifts and runs 24 squarings through
// the shared multiplier; a zero-length segment skips the divider. Reset loads
// the register defaults; no clearing pass. A pending result holds in the
// output register while the next word is taken in; the sequencer waits at its
// end for that register.

module local_magnitude_mlv
    import mlv_pkg::*;
#(
    parameter int TABLE_POINTS = TABLE_POINTS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    mlv_in_if.sink     sample,
    mlv_out_if.source  result,
    mlv_cfg_if.sink    cfg
);

    localparam int PT_W  = $clog2(TABLE_POINTS);
    localparam int IDX_W = $clog2(TABLE_POINTS + 1);

    // configuration
    logic [31:0]        point_reg [TABLE_POINTS];
    logic [2:0]         count_reg;
    logic [15:0]        maxd_reg;
    logic [15:0]        mult_reg;
    logic signed [15:0] offset_reg;

    // sequencer and datapath
    state_t             state_reg, state_next;
    logic [31:0]        amp_reg;
    logic [23:0]        deg_reg;
    logic [31:0]        km_reg, km_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic signed [32:0] loga0_reg, loga0_next;
    logic               neg_reg, neg_next;
    logic [32:0]        m_reg, m_next;
    logic [4:0]         p_reg, p_next;
    logic [23:0]        frac_reg, frac_next;
    logic [4:0]         sq_cnt_reg, sq_cnt_next;
    logic signed [32:0] mag_reg, mag_next;
    logic [1:0]         status_reg, status_next;
    logic signed [19:0] res_reg, res_next;

    logic               out_valid_reg;
    logic [1:0]         out_status_reg;
    logic signed [19:0] out_mag_reg;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;
    logic                     div_start, div_done;
    logic [DIV_W-1:0]         div_dividend, div_q;
    logic                     fin_load;

    // current segment
    logic [PT_W-1:0]    pi0, pi1;
    logic [15:0]        d0, d1, seg_len;
    logic signed [15:0] v0, v1;
    logic [31:0]        seg_lo, seg_hi;
    logic               seg_hit, seg_end, over_limit, amp_zero;
    logic [IDX_W-1:0]   n_eff;
    logic signed [16:0] v_diff;
    logic signed [33:0] v0_q28;

    mlv_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    mlv_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (seg_len),
        .done     (div_done),
        .quotient (div_q)
    );

    assign pi1     = idx_reg[PT_W-1:0];
    assign pi0     = PT_W'(idx_reg - 1'b1);
    assign d0      = point_reg[pi0][31:16];
    assign d1      = point_reg[pi1][31:16];
    assign v0      = point_reg[pi0][15:0];
    assign v1      = point_reg[pi1][15:0];
    assign seg_lo  = {d0, 16'd0};
    assign seg_hi  = {d1, 16'd0};
    assign seg_len = d1 - d0;
    assign seg_hit = (seg_lo <= km_reg) && (km_reg <= seg_hi);
    assign n_eff   = (count_reg > 3'(TABLE_POINTS)) ? IDX_W'(TABLE_POINTS)
                                                    : IDX_W'(count_reg);
    assign seg_end = (idx_reg >= n_eff);
    assign v_diff  = 17'(v1) - 17'(v0);
    assign v0_q28  = {{2{v0[15]}}, v0, 16'd0};
    assign amp_zero = (sample.amplitude_q16 == '0);
    assign over_limit = (maxd_reg != '0) && (km_next > {maxd_reg, 16'd0});

    // derived values from the multiplier, divider and sequencer registers
    logic [PROD_W-1:0]        prod_abs;
    logic [32:0]              sq_val;
    logic signed [5:0]        p_exp;
    logic signed [29:0]       log2_q24;
    logic signed [PROD_W-1:0] l10, total, res_wide;
    logic signed [33:0]       loga0_div;

    assign km_next   = 32'((prod + 66'sd32768) >>> 16);
    assign prod_abs  = prod[PROD_W-1] ? -prod : prod;
    assign sq_val    = prod[63:31];
    assign p_exp     = $signed({1'b0, p_reg}) - 6'sd16;
    assign log2_q24  = {p_exp, frac_reg};
    assign l10       = round_q28(prod);
    assign total     = prod + {{22{offset_reg[15]}}, offset_reg, 28'd0};
    assign res_wide  = round_q28(total);
    assign loga0_div = neg_reg ? v0_q28 - $signed({1'b0, div_q[32:0]})
                               : v0_q28 + $signed({1'b0, div_q[32:0]});
    assign div_dividend = prod_abs[DIV_W-1:0] + DIV_W'(seg_len >> 1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (sample.valid)
                    state_next = amp_zero ? S_FIN : S_KM;
            S_KM:       state_next = S_KM_W;
            S_KM_W:     state_next = over_limit ? S_FIN : S_SEG;
            S_SEG:
                if (seg_end)
                    state_next = S_FIN;
                else if (seg_hit)
                    state_next = (d1 > d0) ? S_INTERP : S_NORM;
            S_INTERP:   state_next = S_INTERP_W;
            S_INTERP_W: state_next = S_DIV;
            S_DIV:
                if (div_done)
                    state_next = S_NORM;
            S_NORM:
                if (m_reg[31])
                    state_next = S_SQ;
            S_SQ:       state_next = S_SQ_W;
            S_SQ_W:     state_next = (sq_cnt_reg == 5'(SQ_STEPS - 1)) ? S_LOG : S_SQ;
            S_LOG:      state_next = S_LOG_W;
            S_LOG_W:    state_next = S_CORR;
            S_CORR:     state_next = S_CORR_W;
            S_CORR_W:   state_next = S_FIN;
            S_FIN:
                if (!out_valid_reg || result.ready)
                    state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // datapath updates and unit controls
    always_comb
    begin
        idx_next    = idx_reg;
        loga0_next  = loga0_reg;
        neg_next    = neg_reg;
        m_next      = m_reg;
        p_next      = p_reg;
        frac_next   = frac_reg;
        sq_cnt_next = sq_cnt_reg;
        mag_next    = mag_reg;
        status_next = status_reg;
        res_next    = res_reg;
        mul_a       = '0;
        mul_b       = '0;
        div_start   = 1'b0;
        fin_load    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                status_next = amp_zero ? ST_AMP : ST_OK;
                res_next    = '0;
            end
            S_KM:
            begin
                mul_a = $signed({9'd0, deg_reg});
                mul_b = KM_PER_DEG_Q16;
            end
            S_KM_W:
            begin
                idx_next = IDX_W'(1);
                if (over_limit)
                    status_next = ST_DIST;
            end
            S_SEG:
            begin
                m_next = {1'b0, amp_reg};
                p_next = 5'd31;
                loga0_next = v0_q28[32:0];
                if (seg_end)
                    status_next = ST_DIST;
                else if (!seg_hit)
                    idx_next = idx_reg + 1'b1;
            end
            S_INTERP:
            begin
                mul_a = $signed({1'b0, km_reg - seg_lo});
                mul_b = MUL_W'(v_diff);
            end
            S_INTERP_W:
            begin
                neg_next  = prod[PROD_W-1];
                div_start = 1'b1;
            end
            S_DIV:
                if (div_done)
                    loga0_next = loga0_div[32:0];
            S_NORM:
            begin
                sq_cnt_next = '0;
                frac_next   = '0;
                if (!m_reg[31])
                begin
                    m_next = {m_reg[31:0], 1'b0};
                    p_next = p_reg - 1'b1;
                end
            end
            S_SQ:
            begin
                mul_a = $signed({1'b0, m_reg[31:0]});
                mul_b = $signed({1'b0, m_reg[31:0]});
            end
            S_SQ_W:
            begin
                sq_cnt_next = sq_cnt_reg + 1'b1;
                if (sq_val[32])
                begin
                    m_next    = {1'b0, sq_val[32:1]};
                    frac_next = {frac_reg[22:0], 1'b1};
                end
                else
                begin
                    m_next    = sq_val;
                    frac_next = {frac_reg[22:0], 1'b0};
                end
            end
            S_LOG:
            begin
                mul_a = MUL_W'(log2_q24);
                mul_b = LOG10_2_Q32;
            end
            S_LOG_W:
                mag_next = l10[32:0] - loga0_reg;
            S_CORR:
            begin
                mul_a = mag_reg;
                mul_b = $signed({17'd0, mult_reg});
            end
            S_CORR_W:
            begin
                if (res_wide > MAG_MAX)
                    res_next = MAG_MAX[19:0];
                else if (res_wide < MAG_MIN)
                    res_next = MAG_MIN[19:0];
                else
                    res_next = res_wide[19:0];
            end
            S_FIN:
                fin_load = !out_valid_reg || result.ready;
            default: ;
        endcase
    end

    // sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && sample.valid)
        begin
            amp_reg <= sample.amplitude_q16;
            deg_reg <= sample.distance_deg_q16;
        end
        if (state_reg == S_KM_W)
            km_reg <= km_next;
        idx_reg    <= idx_next;
        loga0_reg  <= loga0_next;
        neg_reg    <= neg_next;
        m_reg      <= m_next;
        p_reg      <= p_next;
        frac_reg   <= frac_next;
        sq_cnt_reg <= sq_cnt_next;
        mag_reg    <= mag_next;
        status_reg <= status_next;
        res_reg    <= res_next;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fin_load)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fin_load)
        begin
            out_status_reg <= status_reg;
            out_mag_reg    <= res_reg;
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_POINTS; i++)
                point_reg[i] <= POINT_RESET[i];
            count_reg  <= COUNT_RESET;
            maxd_reg   <= '0;
            mult_reg   <= MULT_RESET;
            offset_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index) inside
                REG_POINT0, REG_POINT1, REG_POINT2, REG_POINT3:
                    if (cfg.index < 3'(TABLE_POINTS))
                        point_reg[cfg.index[PT_W-1:0]] <= cfg.data;
                REG_COUNT:  count_reg  <= cfg.data[2:0];
                REG_MAXD:   maxd_reg   <= cfg.data[15:0];
                REG_MULT:   mult_reg   <= cfg.data[15:0];
                REG_OFFSET: offset_reg <= cfg.data[15:0];
                default: ;
            endcase
        end
    end

    assign cfg.ready            = 1'b1;
    assign sample.ready         = (state_reg == S_IDLE);
    assign result.valid         = out_valid_reg;
    assign result.status        = out_status_reg;
    assign result.magnitude_q12 = out_mag_reg;

endmodule
